// ===== src/tdb_pkg.sv =====
// Shared types, constants and table-building functions for the bearing-to-servo block.
// No dependencies; the front, back and top files import this package.
`default_nettype none

package tdb_pkg;

  // Field widths
  localparam int TIME_W  = 20;
  localparam int TURN_W  = 3;
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 13;
  localparam int BASE_W  = 10;
  localparam int DUTY_W  = 16;
  localparam int OFF_W   = 9;
  localparam int ASIN_W  = 17;

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 2'd1;
  localparam logic [TURN_W-1:0]    TURN_RESET      = 3'd3;
  localparam logic [SPEED_W-1:0]   SPEED_RESET     = 16'd1700;

  // Reach mask patterns
  localparam logic [2:0] MASK_NONE      = 3'd0;
  localparam logic [2:0] MASK_ONE       = 3'd1;
  localparam logic [2:0] MASK_TWO       = 3'd2;
  localparam logic [2:0] MASK_ONE_TWO   = 3'd3;
  localparam logic [2:0] MASK_THREE     = 3'd4;
  localparam logic [2:0] MASK_ONE_THREE = 3'd5;
  localparam logic [2:0] MASK_TWO_THREE = 3'd6;
  localparam logic [2:0] MASK_ALL       = 3'd7;

  // Base offsets in degrees
  localparam logic [OFF_W-1:0] OFF_0   = 9'd0;
  localparam logic [OFF_W-1:0] OFF_60  = 9'd60;
  localparam logic [OFF_W-1:0] OFF_120 = 9'd120;
  localparam logic [OFF_W-1:0] OFF_180 = 9'd180;
  localparam logic [OFF_W-1:0] OFF_240 = 9'd240;
  localparam logic [OFF_W-1:0] OFF_300 = 9'd300;

  // Arithmetic constants
  localparam int            P_W          = TIME_W + SPEED_W;
  localparam logic [P_W-1:0] P_SAT       = P_W'(1000000);
  localparam int            Y_W          = 30;
  localparam logic [30:0]   RECIP_15625  = 31'd1125899906;  // floor(2^44 / 15625)
  localparam int            RECIP_15625_SH = 44;
  localparam logic [Y_W-1:0] DIV_15625   = 30'd15625;
  localparam logic [ASIN_W-1:0] Q16_ONE  = 17'd65536;
  localparam int            ASIN_MAX_Q16 = 102944;
  localparam logic [9:0]    DEG_MUL      = 10'd573;
  localparam int            W_W          = 27;
  localparam logic [26:0]   RECIP_10     = 27'd107374183;   // ceil(2^30 / 10)
  localparam int            RECIP_10_SH  = 30;
  localparam int            DEG_W        = 23;
  localparam logic [DEG_W-1:0] DEG_LIMIT = 23'd5963776;     // 91 degrees in Q16
  localparam int            BQ_W         = 27;
  localparam logic [ANGLE_W-1:0] TURN_DEG = 13'd360;
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 13'd2160;
  localparam int            X_W          = 24;
  localparam logic [X_W-1:0] DUTY_ROUND  = 24'd675;
  localparam logic [24:0]   RECIP_1350   = 25'd25451659;    // ceil(2^35 / 1350)
  localparam int            RECIP_1350_SH = 35;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 16'd3277;

  // Default sizes
  localparam int ASIN_DEPTH_DEFAULT = 256;
  localparam int MID_DEPTH_DEFAULT  = 2;
  localparam int OUT_DEPTH_DEFAULT  = 2;

  typedef struct packed {
    logic [2:0]        reach_mask;
    logic [TIME_W-1:0] arrival_one;
    logic [TIME_W-1:0] arrival_two;
    logic [TIME_W-1:0] arrival_three;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] bearing_degrees;
    logic [DUTY_W-1:0]         servo_duty;
    logic                      out_of_range;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic              hold;      // nobody heard: reuse last base angle
    logic              term_neg;  // subtract the asin term from the offset
    logic [OFF_W-1:0]  offset;
    logic [TIME_W-1:0] mag;
  } cls_item_t;

  typedef struct packed {
    logic [TURN_W-1:0]  turn_offset;
    logic [SPEED_W-1:0] speed_over_spacing;
  } cfg_t;

  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
    logic [63:0] q;
    case (n)
      1:       q = t / 6;
      2:       q = t / 20;
      3:       q = t / 42;
      4:       q = t / 72;
      5:       q = t / 110;
      6:       q = t / 156;
      default: q = t / 210;
    endcase
    return q;
  endfunction

  // Taylor sine to the 15th order, Q30 in and out
  function automatic logic [63:0] sine_q30(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] t;
    longint      sum;
    r2  = (r * r) >> 30;
    t   = r;
    sum = longint'(r);
    for (int n = 1; n <= 7; n++) begin
      t = taylor_div((t * r2) >> 30, n);
      if ((n % 2) == 1) sum = sum - longint'(t);
      else              sum = sum + longint'(t);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Largest Q16 angle whose sine stays at or below idx/depth
  function automatic logic [ASIN_W-1:0] asin_entry(input int idx, input int depth);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] target;
    logic [63:0] probe;
    lo     = 64'd0;
    hi     = 64'(ASIN_MAX_Q16);
    target = 64'(idx) << 30;
    while (lo < hi) begin
      mid   = (lo + hi + 64'd1) >> 1;
      probe = sine_q30(mid << 14) * 64'(depth);
      if (probe <= target) lo = mid;
      else                 hi = mid - 64'd1;
    end
    return lo[ASIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/tdb_queue.sv =====
// Small register-based FIFO used between front and back and on the result side.
// Depends on nothing but its parameters.
`default_nettype none

module tdb_queue #(
  parameter int  DEPTH  = 2,
  parameter type item_t = logic
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  output logic  full,
  input  item_t wdata,
  input  wire   pop,
  output logic  empty,
  output item_t rdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && !empty)) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue lost a pushed request");
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && pop && !empty) |=> $stable(count_r))
    else $error("queue count moved on push with pop");
`endif

endmodule

`default_nettype wire

// ===== src/tdb_front.sv =====
// Front end: resolves the reach mask and turns one round into a classified request.
// Depends on tdb_pkg.
`default_nettype none

module tdb_front (
  input  tdb_pkg::in_item_t  in_item,
  output tdb_pkg::cls_item_t cls
);
  import tdb_pkg::*;

  logic [2:0]        mask;
  logic [TIME_W-1:0] ta, tb;
  logic              sub;
  logic [TIME_W:0]   diff;
  logic [TIME_W:0]   diff_abs;
  logic              diff_neg;

  always_comb begin
    logic [TIME_W-1:0] t1, t2, t3;
    t1   = in_item.arrival_one;
    t2   = in_item.arrival_two;
    t3   = in_item.arrival_three;
    mask = in_item.reach_mask;
    // All three heard: drop the latest arrival, sensor one first on ties
    if (mask == MASK_ALL) begin
      priority if (t1 >= t2 && t1 >= t3) mask = MASK_TWO_THREE;
      else if (t2 >= t1 && t2 >= t3)     mask = MASK_ONE_THREE;
      else                               mask = MASK_ONE_TWO;
    end

    ta         = '0;
    tb         = '0;
    sub        = 1'b0;
    cls.hold   = 1'b0;
    cls.offset = OFF_0;
    unique case (mask)
      MASK_ONE:       cls.offset = OFF_0;
      MASK_TWO:       cls.offset = OFF_240;
      MASK_THREE:     cls.offset = OFF_120;
      MASK_ONE_TWO: begin
        cls.offset = OFF_300;
        ta = t2;
        tb = t1;
      end
      MASK_ONE_THREE: begin
        cls.offset = OFF_60;
        ta  = t1;
        tb  = t3;
        sub = 1'b1;
      end
      MASK_TWO_THREE: begin
        cls.offset = OFF_180;
        ta = t3;
        tb = t2;
      end
      default: cls.hold = 1'b1;
    endcase

    diff         = {1'b0, ta} - {1'b0, tb};
    diff_neg     = diff[TIME_W];
    diff_abs     = diff_neg ? -diff : diff;
    cls.mag      = diff_abs[TIME_W-1:0];
    cls.term_neg = diff_neg ^ sub;
  end

endmodule

`default_nettype wire

// ===== src/tdb_back.sv =====
// Back end: pipelined asin bearing, base angle, turn offset and servo duty.
// Depends on tdb_pkg and tdb_queue (result queue).
`default_nettype none

module tdb_back #(
  parameter int ASIN_TABLE_DEPTH = tdb_pkg::ASIN_DEPTH_DEFAULT,
  parameter int OUT_DEPTH        = tdb_pkg::OUT_DEPTH_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  tdb_pkg::cfg_t       cfg,
  input  wire                 req_empty,
  input  tdb_pkg::cls_item_t  req,
  output logic                req_pop,
  input  wire                 out_pop,
  output logic                out_empty,
  output tdb_pkg::out_item_t  out_item
);
  import tdb_pkg::*;

  localparam int IDX_W = $clog2(ASIN_TABLE_DEPTH + 1);
  localparam int POS_W = 16 + IDX_W + 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(ASIN_TABLE_DEPTH);
  localparam int NSTG = 9;

  typedef struct packed {
    logic             hold;
    logic             term_neg;
    logic [OFF_W-1:0] offset;
  } tag_t;

  // Constant asin table, built at elaboration
  logic [ASIN_W-1:0] asin_tbl [0:ASIN_TABLE_DEPTH];
  for (genvar g = 0; g <= ASIN_TABLE_DEPTH; g++) begin : g_tbl
    localparam logic [ASIN_W-1:0] ENTRY = asin_entry(g, ASIN_TABLE_DEPTH);
    assign asin_tbl[g] = ENTRY;
  end

  logic [NSTG:1]      v_r;
  tag_t               tag_r [1:7];
  logic               adv;
  logic               res_full;
  logic               res_push;
  out_item_t          res_item;

  logic [P_W-1:0]     p_s1_r;
  logic               sat_s2_r;
  logic [Y_W-1:0]     y_s2_r;
  logic [15:0]        q0_s2_r;
  logic [ASIN_W-1:0]  m_s3_r;
  logic [ASIN_W-1:0]  a_s4_r, d_s4_r;
  logic [15:0]        frac_s4_r;
  logic [ASIN_W-1:0]  asin_s5_r;
  logic [W_W-1:0]     w_s6_r;
  logic [DEG_W-1:0]   deg_s7_r;
  logic signed [ANGLE_W-1:0] angle_s8_r;
  logic signed [ANGLE_W-1:0] angle_s9_r;
  logic               oor_s9_r;
  logic [X_W-1:0]     x_s9_r;
  logic [BASE_W-1:0]  last_base_r, last_base_nxt;
  logic [DUTY_W-1:0]  last_duty_r, last_duty_nxt;

  // Combinational stage results
  logic [Y_W-1:0]            y_c;
  logic [60:0]               q0_prod;
  logic [Y_W-1:0]            rem_c;
  logic [ASIN_W-1:0]         q_c, m_c;
  logic [POS_W-1:0]          pos_c;
  logic [IDX_W-1:0]          idx_c;
  logic [ASIN_W-1:0]         a_c, d_c;
  logic [32:0]               interp_prod;
  logic [53:0]               deg_prod;
  logic signed [BQ_W-1:0]    bq_c, bq_abs;
  logic [BASE_W-1:0]         bmag_c, base_c;
  logic signed [ANGLE_W-1:0] angle_c;
  logic [ANGLE_W-1:0]        num_c;
  logic                      oor_c;
  logic [50:0]               duty_prod;
  logic [DUTY_W-1:0]         duty_c;

  // The whole pipe holds while the last stage waits on a full result queue
  assign adv     = !(v_r[NSTG] && res_full);
  assign req_pop = adv && !req_empty;

  always_comb begin
    // S2: saturate and divide by 15625 through a reciprocal
    y_c     = {p_s1_r[19:0], 10'b0};
    q0_prod = 61'(y_c) * 61'(RECIP_15625);
    // S3: one correction step
    rem_c = y_s2_r - Y_W'(q0_s2_r) * DIV_15625;
    q_c   = ASIN_W'(q0_s2_r) + ((rem_c >= DIV_15625) ? ASIN_W'(1) : ASIN_W'(0));
    m_c   = sat_s2_r ? Q16_ONE : q_c;
    // S4: table lookup
    pos_c = POS_W'(m_s3_r) * POS_W'(ASIN_TABLE_DEPTH);
    idx_c = pos_c[16 +: IDX_W];
    if (idx_c >= IDX_TOP) begin
      a_c = asin_tbl[IDX_TOP];
      d_c = '0;
    end else begin
      a_c = asin_tbl[idx_c];
      d_c = asin_tbl[idx_c + IDX_W'(1)] - asin_tbl[idx_c];
    end
    // S5: interpolate
    interp_prod = 33'(d_s4_r) * 33'(frac_s4_r);
    // S7: divide by ten through a reciprocal
    deg_prod = 54'(w_s6_r) * 54'(RECIP_10);
    // S8: base angle, truncated toward zero, plus whole turns
    bq_c = $signed({2'b0, tag_r[7].offset, 16'b0});
    if (tag_r[7].term_neg) bq_c = bq_c - $signed(BQ_W'(deg_s7_r));
    else                   bq_c = bq_c + $signed(BQ_W'(deg_s7_r));
    bq_abs = bq_c[BQ_W-1] ? -bq_c : bq_c;
    bmag_c = bq_abs[16 +: BASE_W];
    base_c = bq_c[BQ_W-1] ? -bmag_c : bmag_c;
    last_base_nxt = tag_r[7].hold ? last_base_r : base_c;
    angle_c = $signed(ANGLE_W'($signed(last_base_nxt)))
            + $signed(ANGLE_W'(cfg.turn_offset) * TURN_DEG);
    // S9: range check and duty numerator
    oor_c = angle_s8_r > $signed(ANGLE_LIMIT);
    num_c = angle_s8_r + ANGLE_LIMIT;
    // Result: divide by 1350 through a reciprocal
    duty_prod = 51'(x_s9_r) * 51'(RECIP_1350);
    duty_c    = duty_prod[RECIP_1350_SH +: DUTY_W];
    last_duty_nxt = oor_s9_r ? last_duty_r : duty_c;
  end

  assign res_push                 = v_r[NSTG] && !res_full;
  assign res_item.bearing_degrees = angle_s9_r;
  assign res_item.servo_duty      = last_duty_nxt;
  assign res_item.out_of_range    = oor_s9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      last_base_r <= '0;
      last_duty_r <= DUTY_RESET;
    end else begin
      if (adv) begin
        v_r <= {v_r[NSTG-1:1], req_pop};
        if (v_r[7]) last_base_r <= last_base_nxt;
      end
      if (res_push) last_duty_r <= last_duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[1]   <= '{hold: req.hold, term_neg: req.term_neg, offset: req.offset};
      for (int k = 2; k <= 7; k++) tag_r[k] <= tag_r[k-1];
      p_s1_r     <= P_W'(req.mag) * P_W'(cfg.speed_over_spacing);
      sat_s2_r   <= (p_s1_r >= P_SAT);
      y_s2_r     <= y_c;
      q0_s2_r    <= q0_prod[RECIP_15625_SH +: 16];
      m_s3_r     <= m_c;
      a_s4_r     <= a_c;
      d_s4_r     <= d_c;
      frac_s4_r  <= pos_c[15:0];
      asin_s5_r  <= a_s4_r + interp_prod[16 +: ASIN_W];
      w_s6_r     <= W_W'(asin_s5_r) * W_W'(DEG_MUL);
      deg_s7_r   <= deg_prod[RECIP_10_SH +: DEG_W];
      angle_s8_r <= angle_c;
      angle_s9_r <= angle_s8_r;
      oor_s9_r   <= oor_c;
      x_s9_r     <= {num_c, 11'b0} + DUTY_ROUND;
    end
  end

  tdb_queue #(
    .DEPTH  (OUT_DEPTH),
    .item_t (out_item_t)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_item),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_item)
  );

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r)) else $error("pipe moved while stalled");
  a_m_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (m_s3_r <= Q16_ONE)) else $error("asin argument above one");
  a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] |-> (deg_s7_r < DEG_LIMIT)) else $error("asin term above ninety degrees");
  a_oor_keeps_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && oor_s9_r) |=> $stable(last_duty_r))
    else $error("duty changed on out-of-range result");
`endif

endmodule

`default_nettype wire

// ===== src/tdb_top.sv =====
// Top level of the three-sensor bearing-to-servo block: config registers and the
// front / request queue / back chain. Depends on tdb_pkg, tdb_front, tdb_queue, tdb_back.
`default_nettype none

// Each request is one listening round: a reach mask and three arrival times in
// microseconds. The front end resolves the mask (all three heard: drop the latest,
// sensor one first on ties) and computes the signed time difference in the same
// cycle it accepts the round; a short request queue then decouples it from a
// nine-stage back end that scales by speed_over_spacing, clamps the asin argument
// to one, interpolates a constant asin table of ASIN_TABLE_DEPTH+1 entries built at
// elaboration, converts to degrees, truncates the base angle toward zero, adds
// turn_offset*360 and derives the Q16 servo duty. A round nobody heard reuses the
// last base angle; an angle above 2160 raises out_of_range and repeats the last
// duty. One round enters per clock when the result side keeps popping; throughput
// is limited by how fast results are popped, since the whole back end holds while
// the result queue is full. There is no clearing pass after reset. Write config
// registers only while no round is in flight; cfg_ready is always high and writes
// to an index beyond the list are dropped.
module tdoa_bearing_to_servo #(
  parameter int ASIN_TABLE_DEPTH = tdb_pkg::ASIN_DEPTH_DEFAULT,
  parameter int MID_DEPTH        = tdb_pkg::MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH        = tdb_pkg::OUT_DEPTH_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // round requests
  input  wire                                  in_push,
  output logic                                 in_full,
  input  tdb_pkg::in_item_t                    in_item,
  // results
  input  wire                                  out_pop,
  output logic                                 out_empty,
  output tdb_pkg::out_item_t                   out_item,
  // config writes
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [tdb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [tdb_pkg::SPEED_W-1:0]          cfg_wdata
);
  import tdb_pkg::*;

  logic [TURN_W-1:0]  turn_offset_r;
  logic [SPEED_W-1:0] speed_r;
  cfg_t               cfg;
  cls_item_t          cls;
  cls_item_t          req;
  logic               req_empty;
  logic               req_pop;

  assign cfg_ready = 1'b1;
  assign cfg.turn_offset        = turn_offset_r;
  assign cfg.speed_over_spacing = speed_r;

  // Config registers; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_offset_r <= TURN_RESET;
      speed_r       <= SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TURN_OFFSET: turn_offset_r <= cfg_wdata[TURN_W-1:0];
        CFG_SPEED:       speed_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify the incoming round
  tdb_front u_front (
    .in_item (in_item),
    .cls     (cls)
  );

  // Decouple front and back; full here backs up the input side
  tdb_queue #(
    .DEPTH  (MID_DEPTH),
    .item_t (cls_item_t)
  ) u_req_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (cls),
    .pop   (req_pop),
    .empty (req_empty),
    .rdata (req)
  );

  // Compute the bearing and duty, then hold results for the consumer
  tdb_back #(
    .ASIN_TABLE_DEPTH (ASIN_TABLE_DEPTH),
    .OUT_DEPTH        (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_empty (req_empty),
    .req       (req),
    .req_pop   (req_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
